// File: rtl/urb_pkg.sv
// Shared types and constants for the UART ring buffer block.
package urb_pkg;

    // Function codes as they arrive on the func field
    localparam logic [2:0] FUNC_RX_WORD   = 3'd0;
    localparam logic [2:0] FUNC_HOST_READ = 3'd1;
    localparam logic [2:0] FUNC_HOST_WR   = 3'd2;
    localparam logic [2:0] FUNC_TX_TAKE   = 3'd3;
    localparam logic [2:0] FUNC_CLR_CNT   = 3'd4;

    // Error counter slots
    localparam int unsigned NUM_CNT      = 5;
    localparam logic [2:0]  CNT_OVERFLOW = 3'd0;
    localparam logic [2:0]  CNT_OVERRUN  = 3'd1;
    localparam logic [2:0]  CNT_FRAMING  = 3'd2;
    localparam logic [2:0]  CNT_PARITY   = 3'd3;
    localparam logic [2:0]  CNT_BREAK    = 3'd4;

    // Reported value limits
    localparam logic [15:0] REPORT_MAX = 16'hFFFF;
    localparam logic [7:0]  STATUS_MAX = 8'hFF;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QUEUE_PTR_BITS = 1;

    typedef enum logic [2:0] {
        OP_RX_WORD,
        OP_HOST_READ,
        OP_HOST_WRITE,
        OP_TX_TAKE,
        OP_CLEAR_CNT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       framing;
        logic       parity;
        logic       brk;
        logic       overrun;
    } cmd_t;

endpackage

// File: rtl/urb_front.sv
// Input side: decodes func and packs one command for the queue.
module urb_front
(
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    func,
    input  logic [7:0]    rx_byte,
    input  logic          framing_flag,
    input  logic          parity_flag,
    input  logic          break_flag,
    input  logic          overrun_flag,
    input  logic [7:0]    host_byte,
    input  logic          q_full,
    output logic          push,
    output urb_pkg::cmd_t push_cmd
);
    import urb_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd.framing = framing_flag;
        push_cmd.parity  = parity_flag;
        push_cmd.brk     = break_flag;
        push_cmd.overrun = overrun_flag;
        push_cmd.data    = rx_byte;
        case (func)
            FUNC_RX_WORD:   push_cmd.op = OP_RX_WORD;
            FUNC_HOST_READ: push_cmd.op = OP_HOST_READ;
            FUNC_HOST_WR:
            begin
                push_cmd.op   = OP_HOST_WRITE;
                push_cmd.data = host_byte;
            end
            FUNC_TX_TAKE:   push_cmd.op = OP_TX_TAKE;
            FUNC_CLR_CNT:   push_cmd.op = OP_CLEAR_CNT;
            default:        push_cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: rtl/urb_queue.sv
// Two-entry command queue decoupling the front from the back.
module urb_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  urb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output urb_pkg::cmd_t pop_cmd
);
    import urb_pkg::*;

    cmd_t                      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;

    assign full      = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/urb_back.sv
// Execution side: ring memories, pointers, error counters and result register.
module urb_back
#(
    parameter int unsigned RX_DEPTH   = 256,
    parameter int unsigned TX_DEPTH   = 256,
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          q_valid,
    input  urb_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          read_valid,
    output logic [7:0]    read_byte,
    output logic          write_accepted,
    output logic          send_valid,
    output logic [7:0]    send_byte,
    output logic [7:0]    rx_fill,
    output logic [7:0]    tx_room,
    output logic [15:0]   overflow_count,
    output logic [15:0]   overrun_count,
    output logic [15:0]   framing_count,
    output logic [15:0]   parity_count,
    output logic [15:0]   break_count
);
    import urb_pkg::*;

    localparam int unsigned RPW = $clog2(RX_DEPTH);
    localparam int unsigned TPW = $clog2(TX_DEPTH);
    localparam int unsigned RFW = (RPW + 1 > 8) ? RPW + 1 : 8;
    localparam int unsigned TFW = (TPW + 1 > 8) ? TPW + 1 : 8;
    localparam int unsigned CEW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic                  enable_reg;

    logic [7:0]            rx_mem [RX_DEPTH];
    logic [7:0]            tx_mem [TX_DEPTH];
    logic [7:0]            rx_rd_reg;
    logic [7:0]            tx_rd_reg;

    logic [RPW-1:0]        rx_head_reg, rx_head_next, rx_head_adv;
    logic [RPW-1:0]        rx_tail_reg, rx_tail_next, rx_tail_adv;
    logic [TPW-1:0]        tx_head_reg, tx_head_next, tx_head_adv;
    logic [TPW-1:0]        tx_tail_reg, tx_tail_next, tx_tail_adv;
    logic                  rx_we, tx_we;

    logic [COUNT_BITS-1:0] cnt_reg  [NUM_CNT];
    logic [COUNT_BITS-1:0] cnt_next [NUM_CNT];
    logic [15:0]           cnt_rep  [NUM_CNT];
    logic [15:0]           out_cnt_reg [NUM_CNT];

    logic                  rv_next, wa_next, sv_next;
    logic                  rv_reg, wa_reg, sv_reg;

    logic [RPW:0]          rx_diff;
    logic [TPW:0]          tx_diff;
    logic [TPW:0]          tx_free;
    logic [RFW-1:0]        rx_fill_ext;
    logic [TFW-1:0]        tx_room_ext;
    logic [7:0]            rx_fill_sat, tx_room_sat;

    logic                  out_valid_reg;
    logic                  rd_valid_reg, wr_acc_reg, snd_valid_reg;
    logic [7:0]            rd_byte_reg, snd_byte_reg, rx_fill_reg, tx_room_reg;
    logic                  load;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    assign rx_head_adv = (rx_head_reg == RPW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + RPW'(1);
    assign rx_tail_adv = (rx_tail_reg == RPW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + RPW'(1);
    assign tx_head_adv = (tx_head_reg == TPW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + TPW'(1);
    assign tx_tail_adv = (tx_tail_reg == TPW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + TPW'(1);

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // execute one command against pointers and counters
    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        cnt_next     = cnt_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rv_next      = 1'b0;
        wa_next      = 1'b0;
        sv_next      = 1'b0;
        if (state_reg == S_EXEC && enable_reg)
        begin
            case (cmd_reg.op)
                OP_RX_WORD:
                begin
                    if (cmd_reg.framing)
                    begin
                        cnt_next[CNT_FRAMING] = sat_inc(cnt_reg[CNT_FRAMING]);
                    end
                    if (cmd_reg.parity)
                    begin
                        cnt_next[CNT_PARITY] = sat_inc(cnt_reg[CNT_PARITY]);
                    end
                    if (cmd_reg.brk)
                    begin
                        cnt_next[CNT_BREAK] = sat_inc(cnt_reg[CNT_BREAK]);
                    end
                    if (cmd_reg.overrun)
                    begin
                        cnt_next[CNT_OVERRUN] = sat_inc(cnt_reg[CNT_OVERRUN]);
                    end
                    if (rx_head_adv == rx_tail_reg)
                    begin
                        cnt_next[CNT_OVERFLOW] = sat_inc(cnt_reg[CNT_OVERFLOW]);
                    end
                    else
                    begin
                        rx_we        = 1'b1;
                        rx_head_next = rx_head_adv;
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_head_reg != rx_tail_reg)
                    begin
                        rv_next      = 1'b1;
                        rx_tail_next = rx_tail_adv;
                    end
                end
                OP_HOST_WRITE:
                begin
                    if (tx_head_adv != tx_tail_reg)
                    begin
                        wa_next      = 1'b1;
                        tx_we        = 1'b1;
                        tx_head_next = tx_head_adv;
                    end
                end
                OP_TX_TAKE:
                begin
                    if (tx_head_reg != tx_tail_reg)
                    begin
                        sv_next      = 1'b1;
                        tx_tail_next = tx_tail_adv;
                    end
                end
                OP_CLEAR_CNT:
                begin
                    for (int k = 0; k < NUM_CNT; k++)
                    begin
                        cnt_next[k] = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // status after the item: ring fill, free room, clipped counters
    always_comb
    begin
        rx_diff = {1'b0, rx_head_reg} - {1'b0, rx_tail_reg};
        if (rx_head_reg < rx_tail_reg)
        begin
            rx_diff = rx_diff + (RPW+1)'(RX_DEPTH);
        end
        tx_diff = {1'b0, tx_head_reg} - {1'b0, tx_tail_reg};
        if (tx_head_reg < tx_tail_reg)
        begin
            tx_diff = tx_diff + (TPW+1)'(TX_DEPTH);
        end
        tx_free     = (TPW+1)'(TX_DEPTH - 1) - tx_diff;
        rx_fill_ext = RFW'(rx_diff);
        tx_room_ext = TFW'(tx_free);
        rx_fill_sat = (rx_fill_ext > RFW'(STATUS_MAX)) ? STATUS_MAX : rx_fill_ext[7:0];
        tx_room_sat = (tx_room_ext > TFW'(STATUS_MAX)) ? STATUS_MAX : tx_room_ext[7:0];
        for (int k = 0; k < NUM_CNT; k++)
        begin
            cnt_rep[k] = (CEW'(cnt_reg[k]) > CEW'(REPORT_MAX)) ? REPORT_MAX
                                                                : 16'(cnt_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            for (int k = 0; k < NUM_CNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg  <= cfg_wr_data;
                rx_head_reg <= '0;
                rx_tail_reg <= '0;
                tx_head_reg <= '0;
                tx_tail_reg <= '0;
                for (int k = 0; k < NUM_CNT; k++)
                begin
                    cnt_reg[k] <= '0;
                end
            end
            else
            begin
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                cnt_reg     <= cnt_next;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == S_EXEC)
        begin
            rv_reg <= rv_next;
            wa_reg <= wa_next;
            sv_reg <= sv_next;
        end
        if (load)
        begin
            rd_valid_reg  <= rv_reg;
            rd_byte_reg   <= rv_reg ? rx_rd_reg : 8'd0;
            wr_acc_reg    <= wa_reg;
            snd_valid_reg <= sv_reg;
            snd_byte_reg  <= sv_reg ? tx_rd_reg : 8'd0;
            rx_fill_reg   <= enable_reg ? rx_fill_sat : 8'd0;
            tx_room_reg   <= enable_reg ? tx_room_sat : 8'd0;
            out_cnt_reg   <= cnt_rep;
        end
    end

    // ring memories: one write, one registered read each; the read is taken
    // in the execute cycle so it holds while the result waits in S_DONE
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_head_reg] <= cmd_reg.data;
        end
        if (state_reg == S_EXEC)
        begin
            rx_rd_reg <= rx_mem[rx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_head_reg] <= cmd_reg.data;
        end
        if (state_reg == S_EXEC)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_valid     = rd_valid_reg;
    assign read_byte      = rd_byte_reg;
    assign write_accepted = wr_acc_reg;
    assign send_valid     = snd_valid_reg;
    assign send_byte      = snd_byte_reg;
    assign rx_fill        = rx_fill_reg;
    assign tx_room        = tx_room_reg;
    assign overflow_count = out_cnt_reg[CNT_OVERFLOW];
    assign overrun_count  = out_cnt_reg[CNT_OVERRUN];
    assign framing_count  = out_cnt_reg[CNT_FRAMING];
    assign parity_count   = out_cnt_reg[CNT_PARITY];
    assign break_count    = out_cnt_reg[CNT_BREAK];

endmodule

// File: rtl/uart_ring_buffers_with_error_counts.sv
// Top level of the UART receive/transmit ring buffers with error counters.
//
// Channel   Handshake              Payload
// -------   --------------------   -----------------------------------------------
// input     in_valid / in_ready    func, rx_byte, four error flags, host_byte, host_last
// result    out_valid / out_ready  read/write/send status, bytes, fill, room, counters
// config    cfg_wr_en              cfg_wr_data (enable), no wait
//
// In the back end each item is dispatched from the queue, then executed
// (ring write or registered ring read, pointer and counter update), then its result is loaded.
// The back end takes no new item until the result of the last one is loaded.
// Reset: rings empty, counters zero, disabled; ring contents are not cleared.
// Output stalls hold the back end; the 2-entry queue then fills and drops in_ready.
module uart_ring_buffers_with_error_counts
#(
    parameter int unsigned RX_DEPTH   = 256,
    parameter int unsigned TX_DEPTH   = 256,
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  rx_byte,
    input  logic        framing_flag,
    input  logic        parity_flag,
    input  logic        break_flag,
    input  logic        overrun_flag,
    input  logic [7:0]  host_byte,
    input  logic        host_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        read_valid,
    output logic [7:0]  read_byte,
    output logic        write_accepted,
    output logic        send_valid,
    output logic [7:0]  send_byte,
    output logic [7:0]  rx_fill,
    output logic [7:0]  tx_room,
    output logic [15:0] overflow_count,
    output logic [15:0] overrun_count,
    output logic [15:0] framing_count,
    output logic [15:0] parity_count,
    output logic [15:0] break_count
);
    import urb_pkg::*;

    // host_last marks burst ends for the host side only; it has no effect here.

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // front: decode func into a command
    urb_front u_front
    (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .rx_byte      (rx_byte),
        .framing_flag (framing_flag),
        .parity_flag  (parity_flag),
        .break_flag   (break_flag),
        .overrun_flag (overrun_flag),
        .host_byte    (host_byte),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (push_cmd)
    );

    // short command queue between the two halves
    urb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // back: rings, counters and the result register
    urb_back
    #(
        .RX_DEPTH   (RX_DEPTH),
        .TX_DEPTH   (TX_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_valid        (q_not_empty),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .write_accepted (write_accepted),
        .send_valid     (send_valid),
        .send_byte      (send_byte),
        .rx_fill        (rx_fill),
        .tx_room        (tx_room),
        .overflow_count (overflow_count),
        .overrun_count  (overrun_count),
        .framing_count  (framing_count),
        .parity_count   (parity_count),
        .break_count    (break_count)
    );

`ifndef NO_ASSERTIONS
    // a single item does at most one of read, write, send
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({read_valid, write_accepted, send_valid}) <= 1))
        else $error("more than one ring action in one result");

    // bytes are zero when nothing was popped
    a_idle_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((read_valid || read_byte == 8'd0) &&
                       (send_valid || send_byte == 8'd0)))
        else $error("unused result byte not zero");

    // after a send pop the transmit ring has at least one free slot
    a_send_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_valid) |-> (tx_room != 8'd0))
        else $error("transmit room zero after a send");

    // the back end never pops an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("command popped from empty queue");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the UART ring buffer block with error counters.
`timescale 1ns / 1ps

module testbench;
    import urb_pkg::*;

    // Watchdog: cycles in a row with no item moving on either channel
    localparam int unsigned STALL_LIMIT   = 1000;
    // Quiet cycles after the last result before a register write or the end
    localparam int unsigned DRAIN_HOLDOFF = 8;
    localparam int unsigned RANDOM_ITEMS  = 230;   // per idling phase
    // Flagged words sent before the counter clear
    localparam int unsigned FLAG_WORDS    = 40;
    localparam logic [2:0]  FUNC_MAX      = 3'b111;
    localparam logic [7:0]  RING_SLOTS    = 8'd255;

    // One input item, as driven on the payload ports
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] rx_byte;
        logic       framing;
        logic       parity;
        logic       brk;
        logic       overrun;
        logic [7:0] host_byte;
        logic       host_last;
    } item_t;

    // One result item: status flags, popped bytes, ring levels and counters
    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        write_accepted;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [7:0]  rx_fill;
        logic [7:0]  tx_room;
        logic [15:0] overflow;
        logic [15:0] overrun;
        logic [15:0] framing;
        logic [15:0] parity;
        logic [15:0] brk;
    } status_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic        cfg_wr_data  = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [2:0]  func         = FUNC_RX_WORD;
    logic [7:0]  rx_byte      = '0;
    logic        framing_flag = 1'b0;
    logic        parity_flag  = 1'b0;
    logic        break_flag   = 1'b0;
    logic        overrun_flag = 1'b0;
    logic [7:0]  host_byte    = '0;
    logic        host_last    = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        write_accepted;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic [7:0]  rx_fill;
    logic [7:0]  tx_room;
    logic [15:0] overflow_count;
    logic [15:0] overrun_count;
    logic [15:0] framing_count;
    logic [15:0] parity_count;
    logic [15:0] break_count;

    // Predictor state: both rings, their pointers, the counters and the enable bit
    logic [7:0]  rx_ring [256];
    logic [7:0]  tx_ring [256];
    logic [7:0]  rx_wr_ptr, rx_rd_ptr, tx_wr_ptr, tx_rd_ptr;
    logic [15:0] err_count [NUM_CNT];
    logic        port_on;

    status_t     awaited_status [$];
    int unsigned mismatches    = 0;
    int unsigned stuck_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    uart_ring_buffers_with_error_counts i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .rx_byte        (rx_byte),
        .framing_flag   (framing_flag),
        .parity_flag    (parity_flag),
        .break_flag     (break_flag),
        .overrun_flag   (overrun_flag),
        .host_byte      (host_byte),
        .host_last      (host_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .write_accepted (write_accepted),
        .send_valid     (send_valid),
        .send_byte      (send_byte),
        .rx_fill        (rx_fill),
        .tx_room        (tx_room),
        .overflow_count (overflow_count),
        .overrun_count  (overrun_count),
        .framing_count  (framing_count),
        .parity_count   (parity_count),
        .break_count    (break_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Any enable write empties both rings and zeroes the counters
    function automatic void clear_ports(input logic on);
        port_on   = on;
        rx_wr_ptr = '0;
        rx_rd_ptr = '0;
        tx_wr_ptr = '0;
        tx_rd_ptr = '0;
        for (int k = 0; k < NUM_CNT; k++)
            err_count[k] = '0;
    endfunction

    // Saturating counter bump
    function automatic void bump(input logic [2:0] which);
        if (err_count[which] != REPORT_MAX)
            err_count[which] = err_count[which] + 16'd1;
    endfunction

    // Applies one item to the predictor state and returns the status it reports.
    // Depth is 256, so 8-bit pointers wrap exactly like the ring indexes.
    function automatic status_t predict_status(input item_t it);
        status_t    st;
        logic [7:0] nxt;
        st = '0;
        if (port_on) begin
            case (it.func)
                FUNC_RX_WORD: begin
                    if (it.framing) bump(CNT_FRAMING);
                    if (it.parity)  bump(CNT_PARITY);
                    if (it.brk)     bump(CNT_BREAK);
                    if (it.overrun) bump(CNT_OVERRUN);
                    nxt = rx_wr_ptr + 8'd1;
                    if (nxt == rx_rd_ptr) begin
                        bump(CNT_OVERFLOW);
                    end
                    else begin
                        rx_ring[rx_wr_ptr] = it.rx_byte;
                        rx_wr_ptr = nxt;
                    end
                end
                FUNC_HOST_READ: begin
                    if (rx_wr_ptr != rx_rd_ptr) begin
                        st.read_valid = 1'b1;
                        st.read_byte  = rx_ring[rx_rd_ptr];
                        rx_rd_ptr = rx_rd_ptr + 8'd1;
                    end
                end
                FUNC_HOST_WR: begin
                    nxt = tx_wr_ptr + 8'd1;
                    if (nxt != tx_rd_ptr) begin
                        tx_ring[tx_wr_ptr] = it.host_byte;
                        tx_wr_ptr = nxt;
                        st.write_accepted = 1'b1;
                    end
                end
                FUNC_TX_TAKE: begin
                    if (tx_wr_ptr != tx_rd_ptr) begin
                        st.send_valid = 1'b1;
                        st.send_byte  = tx_ring[tx_rd_ptr];
                        tx_rd_ptr = tx_rd_ptr + 8'd1;
                    end
                end
                FUNC_CLR_CNT: begin
                    for (int k = 0; k < NUM_CNT; k++)
                        err_count[k] = '0;
                end
                default: ;   // unknown codes only report status
            endcase
            st.rx_fill = rx_wr_ptr - rx_rd_ptr;
            st.tx_room = RING_SLOTS - (tx_wr_ptr - tx_rd_ptr);
        end
        st.overflow = err_count[CNT_OVERFLOW];
        st.overrun  = err_count[CNT_OVERRUN];
        st.framing  = err_count[CNT_FRAMING];
        st.parity   = err_count[CNT_PARITY];
        st.brk      = err_count[CNT_BREAK];
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // flags are {framing, parity, break, overrun}
    function automatic item_t make_item(input logic [2:0] f, input logic [7:0] rxb,
                                        input logic [3:0] flags, input logic [7:0] hb,
                                        input logic last);
        item_t it;
        it.func      = f;
        it.rx_byte   = rxb;
        it.framing   = flags[3];
        it.parity    = flags[2];
        it.brk       = flags[1];
        it.overrun   = flags[0];
        it.host_byte = hb;
        it.host_last = last;
        return it;
    endfunction

    // Mostly ring traffic, roughly balanced; the odd counter clear and unknown code
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it   = item_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 30)      it.func = FUNC_RX_WORD;
        else if (pick < 55) it.func = FUNC_HOST_READ;
        else if (pick < 77) it.func = FUNC_HOST_WR;
        else if (pick < 95) it.func = FUNC_TX_TAKE;
        else if (pick < 97) it.func = FUNC_CLR_CNT;
        else                it.func = 3'($urandom_range(FUNC_MAX, FUNC_CLR_CNT + 3'd1));
        return it;
    endfunction

    // Sends one item; returns just after the edge that accepted it.
    // Valid stays high between back-to-back items.
    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= it.func;
        rx_byte      <= it.rx_byte;
        framing_flag <= it.framing;
        parity_flag  <= it.parity;
        break_flag   <= it.brk;
        overrun_flag <= it.overrun;
        host_byte    <= it.host_byte;
        host_last    <= it.host_last;
        forever begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        awaited_status.push_back(predict_status(it));
    endtask

    // Stops sending and waits for every awaited result plus a short quiet period
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_HOLDOFF) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_enable(input logic value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        clear_ports(value);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the port is off: every code is ignored, counters read zero.
    // Writing enable low must keep it that way.
    task automatic test_disabled_port();
        send_item(make_item(FUNC_RX_WORD, 8'hFF, 4'b1111, 8'hFF, 1'b1));
        for (int f = 0; f <= FUNC_MAX; f++)
            send_item(make_item(3'(f), 8'($urandom), 4'($urandom), 8'($urandom),
                                1'($urandom)));
        write_enable(1'b0);
        send_item(make_item(FUNC_HOST_WR, 8'h00, 4'b0000, 8'h00, 1'b0));
        send_item(make_item(FUNC_HOST_READ, 8'h00, 4'b0000, 8'h00, 1'b0));
    endtask

    // Every operation at least once with field extremes, plus empty pops and unknown codes
    task automatic test_each_operation();
        write_enable(1'b1);
        send_item(make_item(FUNC_RX_WORD, 8'hFF, 4'b1111, 8'h00, 1'b0));
        send_item(make_item(FUNC_RX_WORD, 8'h00, 4'b0000, 8'hFF, 1'b1));
        send_item(make_item(FUNC_RX_WORD, 8'h5A, 4'b1010, 8'h00, 1'b0));
        send_item(make_item(FUNC_RX_WORD, 8'hA5, 4'b0101, 8'h00, 1'b0));
        repeat (5)   // last one finds the ring empty
            send_item(make_item(FUNC_HOST_READ, 8'h00, 4'b0000, 8'h00, 1'b0));
        send_item(make_item(FUNC_HOST_WR, 8'h00, 4'b0000, 8'hFF, 1'b1));
        send_item(make_item(FUNC_HOST_WR, 8'h00, 4'b0000, 8'h00, 1'b0));
        repeat (3)
            send_item(make_item(FUNC_TX_TAKE, 8'h00, 4'b0000, 8'h00, 1'b0));
        send_item(make_item(FUNC_CLR_CNT, 8'hFF, 4'b1111, 8'hFF, 1'b1));
        for (int f = FUNC_CLR_CNT + 1; f <= FUNC_MAX; f++)
            send_item(make_item(3'(f), 8'hFF, 4'b1111, 8'hFF, 1'b1));
    endtask

    // Fill each ring past full and drain it past empty, random payloads.
    // Leaves a few bytes behind so the enable write has something to discard.
    task automatic test_ring_limits();
        item_t it;
        write_enable(1'b1);
        repeat (257) begin   // 255 stored, 2 dropped into the overflow counter
            it = random_item();
            it.func = FUNC_RX_WORD;
            send_item(it);
        end
        repeat (256) begin
            it = random_item();
            it.func = FUNC_HOST_READ;
            send_item(it);
        end
        repeat (257) begin   // 255 accepted, 2 refused
            it = random_item();
            it.func = FUNC_HOST_WR;
            send_item(it);
        end
        repeat (256) begin
            it = random_item();
            it.func = FUNC_TX_TAKE;
            send_item(it);
        end
        repeat (12) begin
            it = random_item();
            it.func = ($urandom_range(1) != 0) ? FUNC_RX_WORD : FUNC_HOST_WR;
            send_item(it);
        end
        write_enable(1'b1);
        send_item(make_item(FUNC_HOST_READ, 8'h00, 4'b0000, 8'h00, 1'b0));
        send_item(make_item(FUNC_TX_TAKE, 8'h00, 4'b0000, 8'h00, 1'b0));
    endtask

    // Mixed traffic under three idling patterns. The second phase stops once
    // mid-way until every result is back; the third spends a stretch disabled.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 25; recv_idle_pct = 65; end
                1: begin send_idle_pct = 65; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_enable(1'b1);
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (phase == 1 && n == RANDOM_ITEMS / 2)
                    wait_drained();
                if (phase == 2 && n == RANDOM_ITEMS / 3)
                    write_enable(1'b0);
                if (phase == 2 && n == RANDOM_ITEMS / 3 + 60)
                    write_enable(1'b1);
                send_item(random_item());
            end
        end
    endtask

    // Every flag on a run of words so the four flag error counters climb together,
    // then a clear and one more word to show they count up again.
    task automatic test_counter_clear();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_enable(1'b1);
        repeat (FLAG_WORDS)
            send_item(make_item(FUNC_RX_WORD, 8'($urandom), 4'b1111, 8'($urandom),
                                1'($urandom)));
        send_item(make_item(FUNC_CLR_CNT, 8'h00, 4'b0000, 8'h00, 1'b0));
        send_item(make_item(FUNC_RX_WORD, 8'hC3, 4'b1111, 8'h00, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver stalls at random; drive at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Each result against the oldest prediction, in order
    always @(posedge clk) begin
        status_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_status.size() == 0) begin
                $error("result item with no prediction waiting");
                mismatches++;
            end
            else begin
                want = awaited_status.pop_front();
                check_field("read_valid", 16'(want.read_valid), 16'(read_valid));
                check_field("read_byte", 16'(want.read_byte), 16'(read_byte));
                check_field("write_accepted", 16'(want.write_accepted),
                            16'(write_accepted));
                check_field("send_valid", 16'(want.send_valid), 16'(send_valid));
                check_field("send_byte", 16'(want.send_byte), 16'(send_byte));
                check_field("rx_fill", 16'(want.rx_fill), 16'(rx_fill));
                check_field("tx_room", 16'(want.tx_room), 16'(tx_room));
                check_field("overflow_count", want.overflow,       overflow_count);
                check_field("overrun_count",  want.overrun,        overrun_count);
                check_field("framing_count",  want.framing,        framing_count);
                check_field("parity_count",   want.parity,         parity_count);
                check_field("break_count",    want.brk,            break_count);
            end
        end
    end

    // Watchdog: no item moving on either side for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
        else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_ports(1'b0);
        send_idle_pct = 10;
        recv_idle_pct = 30;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_port();
        test_each_operation();
        test_ring_limits();
        test_random_traffic();
        test_counter_clear();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
